// ===== sv/aar_pkg.sv =====
// ----------------------------------------------------------------------------
// aar_pkg
// Shared types, constants and a helper function for the accelerating
// auto-repeat block.
// ----------------------------------------------------------------------------
package aar_pkg;

  // Direction codes carried on the input and result channels
  localparam logic [2:0] DIR_NONE    = 3'd0;
  localparam logic [2:0] DIR_UNKNOWN = 3'd7;

  // Register map: register index is address bit 2
  localparam int          CFG_ADDR_W          = 3;
  localparam logic        REG_INITIAL_DELAY   = 1'b0;
  localparam logic        REG_REPEAT_INTERVAL = 1'b1;

  // Register reset values, also used when a register holds zero
  localparam logic [15:0] DEFAULT_INITIAL  = 16'd200;
  localparam logic [15:0] DEFAULT_INTERVAL = 16'd700;

  // Repeat count limit and acceleration thresholds
  localparam logic [6:0]  COUNT_MAX = 7'd127;
  localparam logic [6:0]  STAGE1    = 7'd10;
  localparam logic [6:0]  STAGE2    = 7'd30;
  localparam logic [6:0]  STAGE3    = 7'd70;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [15:0] initial_delay;
    logic [15:0] repeat_interval;
  } cfg_t;

  // Input stage contents
  typedef struct packed {
    logic [31:0] now_ms;
    logic [2:0]  direction;
  } item_t;

  // A code that names a real direction
  function automatic logic is_active(input logic [2:0] dir);
    is_active = (dir != DIR_NONE) && (dir != DIR_UNKNOWN);
  endfunction

endpackage

// ===== sv/aar_in_if.sv =====
// ----------------------------------------------------------------------------
// aar_in_if
// Input channel: valid/ready handshake with time stamp and direction code.
// ----------------------------------------------------------------------------
interface aar_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [2:0]  direction;

  modport source (output valid, output now_ms, output direction, input ready);
  modport sink   (input valid, input now_ms, input direction, output ready);
endinterface

// ===== sv/aar_out_if.sv =====
// ----------------------------------------------------------------------------
// aar_out_if
// Result channel: valid/ready handshake with emitted code and skip mark.
// ----------------------------------------------------------------------------
interface aar_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] emitted;
  logic       skip;

  modport source (output valid, output emitted, output skip, input ready);
  modport sink   (input valid, input emitted, input skip, output ready);
  modport mon    (input valid, input emitted, input skip, input ready);
endinterface

// ===== sv/aar_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// aar_cfg_regs
// APB register file holding the initial delay and the repeat interval.
// ----------------------------------------------------------------------------
module aar_cfg_regs
  import aar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [15:0] initial_delay_r;
  logic [15:0] repeat_interval_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes complete in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r   <= DEFAULT_INITIAL;
      repeat_interval_r <= DEFAULT_INTERVAL;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_INITIAL_DELAY:   initial_delay_r   <= pwdata[15:0];
        REG_REPEAT_INTERVAL: repeat_interval_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read data mux
  always_comb begin
    unique case (reg_sel)
      REG_INITIAL_DELAY:   prdata = {16'd0, initial_delay_r};
      REG_REPEAT_INTERVAL: prdata = {16'd0, repeat_interval_r};
      default:             prdata = 32'd0;
    endcase
  end

  assign cfg.initial_delay   = initial_delay_r;
  assign cfg.repeat_interval = repeat_interval_r;

endmodule

// ===== sv/aar_core.sv =====
// ----------------------------------------------------------------------------
// aar_core
// Input register, repeat decision logic with its state, and result register.
// ----------------------------------------------------------------------------
module aar_core
  import aar_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  aar_in_if.sink     in_if,
  aar_out_if.source  out_if
);

  // Pipeline control
  logic        s1_valid_r;
  item_t       s1_item_r;
  logic        out_valid_r;
  logic [2:0]  emitted_r;
  logic        skip_r;
  logic        advance;
  logic        in_fire;
  logic        s1_fire;

  // Repeat state
  logic [2:0]  last_dir_r;
  logic [31:0] deadline_r;
  logic [6:0]  count_r;
  logic [2:0]  last_dir_nxt;
  logic [31:0] deadline_nxt;
  logic [6:0]  count_nxt;
  logic [2:0]  emitted_nxt;
  logic        skip_nxt;

  logic [15:0] first_delay;
  logic [15:0] base_interval;
  logic [15:0] held_delay;
  logic        active;

  // The result register frees up when empty or when it is taken this cycle
  assign advance      = !out_valid_r || out_if.ready;
  assign in_if.ready  = !s1_valid_r || advance;
  assign in_fire      = in_if.valid && in_if.ready;
  assign s1_fire      = s1_valid_r && advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.now_ms    <= in_if.now_ms;
      s1_item_r.direction <= in_if.direction;
    end
  end

  // Delays with zero standing for the default
  assign first_delay   = (cfg.initial_delay != 16'd0) ? cfg.initial_delay : DEFAULT_INITIAL;
  assign base_interval = (cfg.repeat_interval != 16'd0) ? cfg.repeat_interval
                                                        : DEFAULT_INTERVAL;

  // Interval shrinks as repeats mount
  always_comb begin
    if (count_r > STAGE3) begin
      held_delay = base_interval >> 3;
    end else if (count_r > STAGE2) begin
      held_delay = base_interval >> 2;
    end else if (count_r > STAGE1) begin
      held_delay = base_interval >> 1;
    end else begin
      held_delay = base_interval;
    end
  end

  assign active = is_active(s1_item_r.direction);

  // Repeat decision for the item in the input register
  always_comb begin
    emitted_nxt  = DIR_NONE;
    skip_nxt     = 1'b0;
    deadline_nxt = deadline_r;
    count_nxt    = count_r;
    last_dir_nxt = s1_item_r.direction;
    if (s1_item_r.direction != last_dir_r) begin
      // A new code: emit at once if it is a real direction
      if (active) begin
        emitted_nxt  = s1_item_r.direction;
        deadline_nxt = s1_item_r.now_ms + {16'd0, first_delay};
      end else begin
        deadline_nxt = s1_item_r.now_ms;
      end
      count_nxt = 7'd0;
    end else if (active) begin
      // Held direction: repeat once the deadline has strictly passed
      if (deadline_r < s1_item_r.now_ms) begin
        emitted_nxt  = s1_item_r.direction;
        deadline_nxt = s1_item_r.now_ms + {16'd0, held_delay};
        if (count_r < COUNT_MAX) begin
          count_nxt = count_r + 7'd1;
        end
      end else begin
        skip_nxt = 1'b1;
      end
    end else begin
      // Neutral or unknown code held
      deadline_nxt = s1_item_r.now_ms;
      count_nxt    = 7'd0;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dir_r <= DIR_NONE;
      deadline_r <= 32'd0;
      count_r    <= 7'd0;
    end else if (s1_fire) begin
      last_dir_r <= last_dir_nxt;
      deadline_r <= deadline_nxt;
      count_r    <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      emitted_r <= emitted_nxt;
      skip_r    <= skip_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.emitted = emitted_r;
  assign out_if.skip    = skip_r;

endmodule

// ===== sv/accelerating_auto_repeat.sv =====
// ----------------------------------------------------------------------------
// accelerating_auto_repeat
// Auto-repeat for a held direction with acceleration, APB configured.
// ----------------------------------------------------------------------------
// A result passes from the input register through the decision logic to the
// result register, and stays there until out ready takes it.
// Throughput: one transaction per cycle; the input register, decision logic
// and result register form a two-stage pipeline that stalls only on out ready.
// Reset (synchronous, rst_n low): pipeline empty, state zero, initial_delay
// 200 and repeat_interval 700.
module accelerating_auto_repeat
  import aar_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  aar_in_if.sink                in_if,
  aar_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;

  // Configuration registers
  aar_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Datapath
  aar_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .out_if (out_if)
  );

endmodule

// ===== sv/aar_checker.sv =====
// ----------------------------------------------------------------------------
// aar_checker
// Port-level assertions on the result channel of the auto-repeat block.
// ----------------------------------------------------------------------------
module aar_checker
  import aar_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_emitted,
  input logic       out_skip
);

  // A pending transaction stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transaction");

  // A pending transaction keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_emitted) && $stable(out_skip))
    else $error("result payload changed while stalled");

  // Emission and skip exclude each other
  a_emit_or_skip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skip |-> out_emitted == DIR_NONE)
    else $error("skip set together with an emitted direction");

  // The unknown code is never emitted
  a_no_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_emitted != DIR_UNKNOWN)
    else $error("unknown code emitted");

  // Nothing is offered in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind accelerating_auto_repeat aar_checker u_aar_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_emitted (out_if.emitted),
  .out_skip    (out_if.skip)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the accelerating auto-repeat block. Key transactions are sent
// through the input channel. Each one is run through a scoreboard that keeps
// its own copy of the repeat state and queues the expected key result.
// Results are compared field by field in order. The run covers several
// register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
  import aar_pkg::*;

  // Direction codes that the package does not name
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;
  localparam logic [2:0] DIR_LTRIG = 3'd5;
  localparam logic [2:0] DIR_RTRIG = 3'd6;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 241;
  localparam int DRAIN_CYCLES    = 6;

  typedef struct packed {
    logic [2:0] emitted;
    logic       skip;
  } key_result_t;

  // Scoreboard: predicts the key result of every accepted transaction and
  // checks the results in order.
  class repeat_scoreboard;
    logic [15:0] first_delay;
    logic [15:0] base_interval;
    logic [2:0]  last_dir;
    logic [31:0] deadline;
    logic [6:0]  repeat_count;
    key_result_t pending_keys[$];
    int          errors;

    function new();
      first_delay   = DEFAULT_INITIAL;
      base_interval = DEFAULT_INTERVAL;
      last_dir      = DIR_NONE;
      deadline      = '0;
      repeat_count  = '0;
      errors        = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] value);
      if (idx == REG_INITIAL_DELAY) begin
        first_delay = value;
      end else begin
        base_interval = value;
      end
    endfunction

    function void note_key(logic [31:0] now, logic [2:0] dir);
      key_result_t res;
      logic [15:0] step;
      logic        real_dir;
      res      = '{emitted: DIR_NONE, skip: 1'b0};
      real_dir = (dir != DIR_NONE) && (dir != DIR_UNKNOWN);
      if (dir != last_dir) begin
        // A new code: a real direction fires at once and arms the first delay.
        if (real_dir) begin
          res.emitted = dir;
          deadline    = now + ((first_delay != 0) ? first_delay : DEFAULT_INITIAL);
        end else begin
          deadline = now;
        end
        repeat_count = '0;
      end else if (real_dir) begin
        // Held direction: repeat only once the deadline lies strictly behind.
        if (deadline < now) begin
          step = (base_interval != 0) ? base_interval : DEFAULT_INTERVAL;
          if (repeat_count > STAGE3) begin
            step = step >> 3;
          end else if (repeat_count > STAGE2) begin
            step = step >> 2;
          end else if (repeat_count > STAGE1) begin
            step = step >> 1;
          end
          res.emitted = dir;
          if (repeat_count < COUNT_MAX) begin
            repeat_count = repeat_count + 7'd1;
          end
          deadline = now + step;
        end else begin
          res.skip = 1'b1;
        end
      end else begin
        deadline     = now;
        repeat_count = '0;
      end
      last_dir = dir;
      pending_keys.push_back(res);
    endfunction

    function void check_result(logic [2:0] emitted, logic skip);
      key_result_t want;
      if (pending_keys.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: emitted %0d skip %0b",
                 $time, emitted, skip);
        return;
      end
      want = pending_keys.pop_front();
      if (emitted !== want.emitted) begin
        errors++;
        $display("%0t: emitted mismatch: expected %0d actual %0d",
                 $time, want.emitted, emitted);
      end
      if (skip !== want.skip) begin
        errors++;
        $display("%0t: skip mismatch: expected %0b actual %0b",
                 $time, want.skip, skip);
      end
    endfunction

    function int pending();
      return pending_keys.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  aar_in_if  in_ch ();
  aar_out_if out_ch ();

  repeat_scoreboard sb = new();

  int          send_idle_pct;
  int          recv_stall_pct;
  int          items_sent;
  logic [31:0] cur_time;

  int send_idle_plan  [PHASES] = '{0, 45, 0, 7, 0, 45, 0, 7};
  int recv_stall_plan [PHASES] = '{0, 0, 45, 7, 0, 0, 45, 7};

  accelerating_auto_repeat dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Each accepted transaction is predicted, each accepted result is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_key(in_ch.now_ms, in_ch.direction);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.emitted, out_ch.skip);
      end
    end
  end

  // Sends one key transaction, with random idle cycles ahead of it.
  task automatic send_key(input logic [31:0] now, input logic [2:0] dir);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now_ms    <= now;
    in_ch.direction <= dir;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops traffic and waits until every expected result has arrived.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, then access phase until pready.
  task automatic write_register(input logic idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  // Longest delay the current settings can arm, with zero read as default.
  function automatic int longest_delay();
    int first_eff;
    int base_eff;
    first_eff = (sb.first_delay != 0) ? sb.first_delay : DEFAULT_INITIAL;
    base_eff  = (sb.base_interval != 0) ? sb.base_interval : DEFAULT_INTERVAL;
    return (first_eff > base_eff) ? first_eff : base_eff;
  endfunction

  // Holds one code for a number of transactions. With sure_fire every step
  // passes the deadline, so each step repeats and the repeat count climbs.
  task automatic hold_run(input logic [2:0] dir, input int len, input bit sure_fire);
    int span;
    int i;
    span = longest_delay();
    for (i = 0; i < len; i++) begin
      if (sure_fire) begin
        cur_time += span + 1;
      end else begin
        case ($urandom_range(3))
          0: cur_time += $urandom_range(2);
          default: cur_time += $urandom_range(span + span / 4 + 2);
        endcase
      end
      send_key(cur_time, dir);
    end
  endtask

  // Random traffic: mostly held directions with random timing, some
  // neutral and unknown codes, time jumps near the wrap point and plain noise.
  task automatic random_traffic(input int quota, input bit long_hold);
    int          stop_at;
    int          i;
    logic [2:0]  dir;
    stop_at = items_sent + quota;
    if (long_hold) begin
      hold_run(3'($urandom_range(1, 6)), 135, 1'b1);
    end
    while (items_sent < stop_at) begin
      dir = 3'($urandom_range(1, 6));
      case ($urandom_range(9))
        0, 1, 2, 3, 4: hold_run(dir, $urandom_range(1, 25), 1'b0);
        5: hold_run(dir, $urandom_range(40, 80), 1'b1);
        6: hold_run($urandom_range(1) ? DIR_NONE : DIR_UNKNOWN, $urandom_range(1, 4), 1'b0);
        7: begin
          cur_time = $urandom;
          send_key(cur_time, 3'($urandom_range(7)));
        end
        8: begin
          cur_time = 32'hFFFF_FFFF - 32'($urandom_range(longest_delay()));
          hold_run(dir, $urandom_range(3, 10), 1'b0);
        end
        default: begin
          for (i = 0; i < 4; i++) begin
            cur_time += $urandom_range(300);
            send_key(cur_time, 3'($urandom_range(7)));
          end
        end
      endcase
    end
  endtask

  // Main sequence
  initial begin
    int          p;
    logic [15:0] delay_val;
    logic [15:0] interval_val;

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.now_ms    <= '0;
    in_ch.direction <= DIR_NONE;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    cur_time        = 32'd5000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first press, strict deadline compare, every code,
    // neutral and unknown held, and deadline wrap near the top of time.
    send_key(32'd1000, DIR_UP);
    send_key(32'd1100, DIR_UP);
    send_key(32'd1200, DIR_UP);
    send_key(32'd1201, DIR_UP);
    send_key(32'd1202, DIR_DOWN);
    send_key(32'd1203, DIR_LEFT);
    send_key(32'd1204, DIR_RIGHT);
    send_key(32'd1205, DIR_LTRIG);
    send_key(32'd1206, DIR_RTRIG);
    send_key(32'd1207, DIR_RTRIG);
    send_key(32'd1208, DIR_NONE);
    send_key(32'd1209, DIR_NONE);
    send_key(32'd1210, DIR_UNKNOWN);
    send_key(32'd1211, DIR_UNKNOWN);
    send_key(32'd1212, DIR_UP);
    send_key(32'hFFFF_FFF0, DIR_DOWN);
    send_key(32'hFFFF_FFF8, DIR_DOWN);
    send_key(32'h0000_0000, DIR_DOWN);
    send_key(32'hFFFF_FFFF, DIR_LEFT);
    send_key(32'h0000_0000, DIR_NONE);
    send_key(32'hFFFF_FFFF, DIR_NONE);

    // Random phases, each with its own register setting and idle pattern.
    for (p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        wait_idle();
        case (p)
          1: begin
            delay_val    = 16'd0;
            interval_val = 16'd0;
          end
          2: begin
            delay_val    = 16'hFFFF;
            interval_val = 16'hFFFF;
          end
          3: begin
            delay_val    = 16'd1;
            interval_val = 16'd1;
          end
          5: begin
            delay_val    = 16'd3;
            interval_val = 16'd8;
          end
          6: begin
            delay_val    = 16'd500;
            interval_val = 16'd40;
          end
          default: begin
            delay_val    = 16'($urandom);
            interval_val = 16'($urandom);
          end
        endcase
        write_register(REG_INITIAL_DELAY, delay_val);
        write_register(REG_REPEAT_INTERVAL, interval_val);
      end
      send_idle_pct  = send_idle_plan[p];
      recv_stall_pct = recv_stall_plan[p];
      random_traffic(ITEMS_PER_PHASE, (p % 2) == 0);
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aar_pkg.sv
sv/aar_in_if.sv
sv/aar_out_if.sv
sv/aar_cfg_regs.sv
sv/aar_core.sv
sv/accelerating_auto_repeat.sv
sv/aar_checker.sv
test/testbench.sv
